/* hw/rtl/jts_pkg.sv */
`default_nettype none

package jts_pkg;

  // Default nesting depth of the container stack
  localparam int unsigned DEFAULT_STACK_DEPTH = 32;

  // Most bytes one input transaction can produce
  localparam int unsigned JOB_BYTES = 9;
  localparam int unsigned JOB_CNT_W = $clog2(JOB_BYTES + 1);
  localparam int unsigned JOB_IDX_W = $clog2(JOB_BYTES);

  // One classified item: the bytes it emits, in order
  typedef struct packed {
    logic [JOB_BYTES-1:0][7:0] bytes;
    logic [JOB_CNT_W-1:0]      count;
    logic                      err;
  } job_t;

endpackage

`default_nettype wire

/* hw/rtl/json_token_serializer_unit.sv */
`default_nettype none

// Channel  Handshake              Payload
// -------  ---------------------  ----------------------------------------
// in       in_valid / in_ready    cmd, data_byte, byte_present, last_byte
// out      out_valid / out_ready  out_byte, run_last, depth_error
//
// An item is accepted and queued (two entries) as a byte list.
// The output sends one byte per cycle while out_ready is high; most items
// give one or two bytes, escapes and literal words more, up to nine.
// A closer that reopens a parent container holds in_ready low for one cycle
// while the parent entry is read back from the stack memory.
// Reset clears the nesting level, the open-string flag and the queue; the
// stack memory is not cleared.

module json_token_serializer_unit #(
  parameter int unsigned STACK_DEPTH = jts_pkg::DEFAULT_STACK_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [3:0]  cmd,
  input  wire logic [7:0]  data_byte,
  input  wire logic        byte_present,
  input  wire logic        last_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_byte,
  output logic             run_last,
  output logic             depth_error
);

  logic          q_full;
  logic          job_valid;
  jts_pkg::job_t job;
  logic          q_pop;
  logic          q_valid;
  jts_pkg::job_t q_data;

  jts_front #(.STACK_DEPTH(STACK_DEPTH)) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .cmd          (cmd),
    .data_byte    (data_byte),
    .byte_present (byte_present),
    .last_byte    (last_byte),
    .q_full       (q_full),
    .job_valid    (job_valid),
    .job          (job)
  );

  jts_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (job_valid),
    .push_data (job),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_data  (q_data)
  );

  jts_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_data      (q_data),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .run_last    (run_last),
    .depth_error (depth_error)
  );

endmodule

`default_nettype wire

/* hw/rtl/jts_front.sv */
`default_nettype none

module jts_front #(
  parameter int unsigned STACK_DEPTH = jts_pkg::DEFAULT_STACK_DEPTH
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic [3:0]   cmd,
  input  wire logic [7:0]   data_byte,
  input  wire logic         byte_present,
  input  wire logic         last_byte,
  input  wire logic         q_full,
  output logic              job_valid,
  output jts_pkg::job_t     job
);

  localparam int unsigned LW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  // Token codes
  localparam logic [3:0] CMD_ARR_BEGIN = 4'd0;
  localparam logic [3:0] CMD_ARR_END   = 4'd1;
  localparam logic [3:0] CMD_OBJ_BEGIN = 4'd2;
  localparam logic [3:0] CMD_OBJ_END   = 4'd3;
  localparam logic [3:0] CMD_STRING    = 4'd4;
  localparam logic [3:0] CMD_NUMBER    = 4'd5;
  localparam logic [3:0] CMD_TRUE      = 4'd6;
  localparam logic [3:0] CMD_FALSE     = 4'd7;
  localparam logic [3:0] CMD_NULL      = 4'd8;

  // Member-count marker of a stack entry
  localparam logic [1:0] MARK_NONE = 2'd0;
  localparam logic [1:0] MARK_ODD  = 2'd1;
  localparam logic [1:0] MARK_EVEN = 2'd2;

  typedef struct packed {
    logic [1:0] mark;
    logic       obj;
  } entry_t;

  typedef struct packed {
    logic [5:0][7:0] bytes;
    logic [2:0]      len;
  } esc_t;

  function automatic entry_t bump(input entry_t e);
    entry_t r;
    r.obj  = e.obj;
    r.mark = (e.mark == MARK_ODD) ? MARK_EVEN : MARK_ODD;
    return r;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    logic [7:0] r;
    if (n < 4'd10) r = 8'h30 + {4'd0, n};
    else r = 8'h57 + {4'd0, n};
    return r;
  endfunction

  // Escaped form of one content byte
  function automatic esc_t escape(input logic [7:0] c);
    esc_t r;
    r.bytes = '0;
    r.bytes[0] = 8'h5c;
    r.len = 3'd2;
    unique case (c)
      8'h08: r.bytes[1] = 8'h62;
      8'h09: r.bytes[1] = 8'h74;
      8'h0a: r.bytes[1] = 8'h6e;
      8'h0c: r.bytes[1] = 8'h66;
      8'h0d: r.bytes[1] = 8'h72;
      8'h22: r.bytes[1] = 8'h22;
      8'h5c: r.bytes[1] = 8'h5c;
      default: begin
        if (c <= 8'h1f) begin
          r.bytes[1] = 8'h75;
          r.bytes[2] = 8'h30;
          r.bytes[3] = 8'h30;
          r.bytes[4] = hex_char(c[7:4]);
          r.bytes[5] = hex_char(c[3:0]);
          r.len = 3'd6;
        end else begin
          r.bytes[0] = c;
          r.len = 3'd1;
        end
      end
    endcase
    return r;
  endfunction

  // Stack: top entry cached in a register, lower entries in memory
  entry_t          mem [STACK_DEPTH];
  entry_t          top, top_next;
  entry_t          rd_q;
  logic [LW-1:0]   level, level_next;
  logic            string_open, string_open_next;
  logic            reload, reload_next;
  logic            mem_we;
  logic [LW-1:0]   level_m1, level_m2;
  logic            accept;

  assign accept   = in_valid && in_ready;
  assign in_ready = !rst && !reload && !q_full;
  assign level_m1 = level - LW'(1);
  assign level_m2 = level - LW'(2);

  // Classify the item and build its byte list
  always_comb begin
    logic [1:0][7:0] p;
    logic [1:0]      plen;
    logic [6:0][7:0] b;
    logic [2:0]      blen;
    entry_t          top1;
    logic            sep_en;
    logic [7:0]      sep_byte;
    logic            err;
    esc_t            esc;
    logic [3:0]      k;

    p = '0;
    plen = 2'd0;
    b = '0;
    blen = 3'd0;
    err = 1'b0;
    sep_en = 1'b0;
    sep_byte = 8'h00;
    top1 = top;
    esc = escape(data_byte);
    top_next = top;
    level_next = level;
    string_open_next = string_open;
    reload_next = 1'b0;
    mem_we = 1'b0;

    if (cmd == CMD_STRING || cmd == CMD_NUMBER) begin
      // content of a quoted token
      sep_en = (level != '0) && (top.mark != MARK_NONE);
      sep_byte = (!top.obj || top.mark == MARK_EVEN) ? 8'h2c : 8'h3a;
      if (!string_open) begin
        if (sep_en) begin
          p[plen[0]] = sep_byte;
          plen = plen + 2'd1;
        end
        p[plen[0]] = 8'h22;
        plen = plen + 2'd1;
      end
      if (byte_present) begin
        b[5:0] = esc.bytes;
        blen = esc.len;
      end
      string_open_next = 1'b1;
      if (last_byte) begin
        b[blen] = 8'h22;
        blen = blen + 3'd1;
        top_next = bump(top);
        string_open_next = 1'b0;
      end
    end else if (cmd <= CMD_NULL) begin
      // implicit close of an open string
      if (string_open) begin
        p[0] = 8'h22;
        plen = 2'd1;
        top1 = bump(top);
        string_open_next = 1'b0;
      end
      top_next = top1;
      sep_en = (level != '0) && (top1.mark != MARK_NONE);
      sep_byte = (!top1.obj || top1.mark == MARK_EVEN) ? 8'h2c : 8'h3a;
      unique case (cmd) inside
        CMD_ARR_BEGIN, CMD_OBJ_BEGIN: begin
          if (level == LW'(STACK_DEPTH)) begin
            b[0] = 8'h00;
            blen = 3'd1;
            err = 1'b1;
          end else begin
            if (sep_en) begin
              p[plen[0]] = sep_byte;
              plen = plen + 2'd1;
            end
            b[0] = (cmd == CMD_ARR_BEGIN) ? 8'h5b : 8'h7b;
            blen = 3'd1;
            mem_we = (level != '0);
            top_next.obj = (cmd == CMD_OBJ_BEGIN);
            top_next.mark = MARK_NONE;
            level_next = level + LW'(1);
          end
        end
        CMD_ARR_END, CMD_OBJ_END: begin
          b[0] = (cmd == CMD_ARR_END) ? 8'h5d : 8'h7d;
          blen = 3'd1;
          if (level != '0) begin
            level_next = level_m1;
            reload_next = (level > LW'(1));
          end
        end
        CMD_TRUE: begin
          b[3:0] = {8'h65, 8'h75, 8'h72, 8'h74};
          blen = 3'd4;
        end
        CMD_FALSE: begin
          b[4:0] = {8'h65, 8'h73, 8'h6c, 8'h61, 8'h66};
          blen = 3'd5;
        end
        default: begin
          b[3:0] = {8'h6c, 8'h6c, 8'h75, 8'h6e};
          blen = 3'd4;
        end
      endcase
      // literal words take a separator and count as a member
      if (cmd == CMD_TRUE || cmd == CMD_FALSE || cmd == CMD_NULL) begin
        if (sep_en) begin
          p[plen[0]] = sep_byte;
          plen = plen + 2'd1;
        end
        top_next = bump(top1);
      end
    end

    // pack prefix and body into one list
    job.err = err;
    job.count = jts_pkg::JOB_CNT_W'({2'd0, plen} + {1'b0, blen});
    for (int i = 0; i < int'(jts_pkg::JOB_BYTES); i++) begin
      k = 4'(i) - {2'd0, plen};
      if (4'(i) < {2'd0, plen}) job.bytes[i] = p[i[0]];
      else if (k < 4'd7) job.bytes[i] = b[k[2:0]];
      else job.bytes[i] = 8'h00;
    end
    job_valid = accept && (job.count != '0);
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      level <= '0;
      string_open <= 1'b0;
      reload <= 1'b0;
    end else if (reload) begin
      reload <= 1'b0;
    end else if (accept) begin
      level <= level_next;
      string_open <= string_open_next;
      reload <= reload_next;
    end
  end

  // Top entry: updated per item, refilled from memory after a pop
  always_ff @(posedge clk) begin
    if (reload) top <= bump(rd_q);
    else if (accept) top <= top_next;
  end

  // Parent entry as it stands after any implicit string close
  function automatic entry_t top_of_push();
    entry_t r;
    r = top;
    if (string_open) r = bump(top);
    return r;
  endfunction

  // Stack memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (accept && mem_we) mem[level_m1[AW-1:0]] <= top_of_push();
    rd_q <= mem[level_m2[AW-1:0]];
  end

  assert property (@(posedge clk) disable iff (rst) level <= LW'(STACK_DEPTH))
    else $error("nesting level beyond stack depth");
  assert property (@(posedge clk) disable iff (rst)
    accept && (cmd == CMD_ARR_END || cmd == CMD_OBJ_END) && level > LW'(1) |=> !in_ready)
    else $error("no refill cycle after a pop");

endmodule

`default_nettype wire

/* hw/rtl/jts_queue.sv */
`default_nettype none

module jts_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire jts_pkg::job_t  push_data,
  output logic                full,
  input  wire logic           pop,
  output logic                pop_valid,
  output jts_pkg::job_t       pop_data
);

  // Two-entry job queue between front and back
  jts_pkg::job_t slots [2];
  logic          wr_ptr, rd_ptr;
  logic [1:0]    cnt;

  assign full      = (cnt == 2'd2);
  assign pop_valid = (cnt != 2'd0);
  assign pop_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      if (push && !pop) cnt <= cnt + 2'd1;
      else if (pop && !push) cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

  assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("job pushed into full queue");
  assert property (@(posedge clk) disable iff (rst) !(pop && !pop_valid))
    else $error("job popped from empty queue");

endmodule

`default_nettype wire

/* hw/rtl/jts_back.sv */
`default_nettype none

module jts_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           q_valid,
  input  wire jts_pkg::job_t  q_data,
  output logic                q_pop,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [7:0]          out_byte,
  output logic                run_last,
  output logic                depth_error
);

  // Current job and the index of the byte on the output
  jts_pkg::job_t                   cur;
  logic                            cur_valid;
  logic [jts_pkg::JOB_IDX_W-1:0]   idx;
  logic                            at_last;

  assign at_last     = (jts_pkg::JOB_CNT_W'(idx) == cur.count - jts_pkg::JOB_CNT_W'(1));
  assign out_valid   = cur_valid;
  assign out_byte    = cur.bytes[idx];
  assign run_last    = at_last;
  assign depth_error = cur.err && at_last;
  assign q_pop       = q_valid && (!cur_valid || (out_ready && at_last));

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx <= '0;
    end else if (!cur_valid || (out_ready && at_last)) begin
      cur_valid <= q_valid;
      idx <= '0;
    end else if (out_ready) begin
      idx <= idx + jts_pkg::JOB_IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur <= q_data;
  end

  assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> (cur.count != '0) && (jts_pkg::JOB_CNT_W'(idx) < cur.count))
    else $error("byte index outside current job");

endmodule

`default_nettype wire

/* bench/jts_bench_pkg.sv */
package jts_bench_pkg;

  // Token codes carried on cmd
  typedef enum logic [3:0] {
    TOK_ARR_OPEN  = 4'd0,
    TOK_ARR_CLOSE = 4'd1,
    TOK_OBJ_OPEN  = 4'd2,
    TOK_OBJ_CLOSE = 4'd3,
    TOK_STRING    = 4'd4,
    TOK_NUMBER    = 4'd5,
    TOK_TRUE      = 4'd6,
    TOK_FALSE     = 4'd7,
    TOK_NULL      = 4'd8
  } token_e;

  // Codes above TOK_NULL carry no meaning and are dropped by the block
  localparam logic [3:0] TOK_UNUSED_LO = 4'd9;
  localparam logic [3:0] TOK_UNUSED_HI = 4'd15;

endpackage

/* bench/json_token_checker.sv */
module json_token_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [3:0] cmd,
  input  logic [7:0] data_byte,
  input  logic       byte_present,
  input  logic       last_byte,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_byte,
  input  logic       run_last,
  input  logic       depth_error,
  output int         fail_count,
  output int         pending
);

  localparam int unsigned NEST_MAX = jts_pkg::DEFAULT_STACK_DEPTH;
  localparam int REPORT_MAX = 10;

  // Member-count marker kept in bits 2..1 of a stack entry
  localparam logic [1:0] MARK_NONE = 2'd0;
  localparam logic [1:0] MARK_ODD  = 2'd1;
  localparam logic [1:0] MARK_EVEN = 2'd2;

  typedef struct packed {
    logic [7:0] text;
    logic       last;
    logic       err;
  } text_beat_t;

  text_beat_t  text_q[$];     // bytes still owed by the block, oldest first
  logic [7:0]  step_bytes[$]; // bytes produced by the current transaction
  logic [2:0]  nest_mem[NEST_MAX];
  int unsigned nest_depth = 0;
  logic        str_open = 1'b0;
  int          fails = 0;

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    return (n < 4'd10) ? (8'h30 + {4'h0, n}) : (8'h57 + {4'h0, n});
  endfunction

  task automatic emit(input logic [7:0] b);
    step_bytes.push_back(b);
  endtask

  task automatic emit_word(input string w);
    for (int i = 0; i < w.len(); i++) emit(w[i]);
  endtask

  // Advance the member count of the innermost container
  task automatic bump_mark();
    logic [2:0] e;
    logic [1:0] m;
    if (nest_depth > 0) begin
      e = nest_mem[nest_depth-1];
      m = (e[2:1] == MARK_ODD) ? MARK_EVEN : MARK_ODD;
      nest_mem[nest_depth-1] = {m, e[0]};
    end
  endtask

  // Comma or colon ahead of a new value
  task automatic emit_separator();
    logic [2:0] e;
    if (nest_depth > 0) begin
      e = nest_mem[nest_depth-1];
      if (e[2:1] != MARK_NONE) begin
        if (!e[0] || e[2:1] == MARK_EVEN) emit_word(",");
        else emit_word(":");
      end
    end
  endtask

  task automatic emit_content(input logic [7:0] c);
    case (c)
      8'h08: emit_word("\\b");
      8'h09: emit_word("\\t");
      8'h0a: emit_word("\\n");
      8'h0c: emit_word("\\f");
      8'h0d: emit_word("\\r");
      8'h22: emit_word("\\\"");
      8'h5c: emit_word("\\\\");
      default: begin
        if (c <= 8'h1f) begin
          emit_word("\\u00");
          emit(hex_char(c[7:4]));
          emit(hex_char(c[3:0]));
        end else begin
          emit(c);
        end
      end
    endcase
  endtask

  task automatic close_text();
    emit_word("\"");
    bump_mark();
    str_open = 1'b0;
  endtask

  // Work out the bytes one input transaction owes and queue them
  task automatic predict_token(input logic [3:0] c, input logic [7:0] d,
                               input logic p, input logic l);
    logic       overflow;
    text_beat_t beat;
    overflow = 1'b0;
    step_bytes.delete();
    if (c <= jts_bench_pkg::TOK_NULL) begin
      if (c == jts_bench_pkg::TOK_STRING || c == jts_bench_pkg::TOK_NUMBER) begin
        if (!str_open) begin
          emit_separator();
          emit_word("\"");
          str_open = 1'b1;
        end
        if (p) emit_content(d);
        if (l) close_text();
      end else begin
        if (str_open) close_text();
        if (c == jts_bench_pkg::TOK_ARR_OPEN || c == jts_bench_pkg::TOK_OBJ_OPEN) begin
          if (nest_depth >= NEST_MAX) begin
            overflow = 1'b1;
          end else begin
            emit_separator();
            emit_word((c == jts_bench_pkg::TOK_ARR_OPEN) ? "[" : "{");
            nest_mem[nest_depth] = {MARK_NONE, c == jts_bench_pkg::TOK_OBJ_OPEN};
            nest_depth++;
          end
        end else if (c == jts_bench_pkg::TOK_ARR_CLOSE ||
                     c == jts_bench_pkg::TOK_OBJ_CLOSE) begin
          emit_word((c == jts_bench_pkg::TOK_ARR_CLOSE) ? "]" : "}");
          if (nest_depth > 0) nest_depth--;
          bump_mark();
        end else begin
          emit_separator();
          if (c == jts_bench_pkg::TOK_TRUE) emit_word("true");
          else if (c == jts_bench_pkg::TOK_FALSE) emit_word("false");
          else emit_word("null");
          bump_mark();
        end
      end
    end
    // a dropped push keeps run_last off the bytes of an implicit close
    for (int i = 0; i < step_bytes.size(); i++) begin
      beat.text = step_bytes[i];
      beat.last = (i == step_bytes.size() - 1) && !overflow;
      beat.err  = 1'b0;
      text_q.push_back(beat);
    end
    if (overflow) begin
      beat.text = 8'h00;
      beat.last = 1'b1;
      beat.err  = 1'b1;
      text_q.push_back(beat);
    end
  endtask

  // Compare one output transaction with the oldest owed byte
  task automatic check_beat();
    text_beat_t want;
    if (text_q.size() == 0) begin
      fails++;
      if (fails <= REPORT_MAX)
        $display("unexpected output: byte %02h run_last %0b depth_error %0b",
                 out_byte, run_last, depth_error);
    end else begin
      want = text_q.pop_front();
      if (out_byte !== want.text || run_last !== want.last || depth_error !== want.err) begin
        fails++;
        if (fails <= REPORT_MAX)
          $display("output mismatch: expected byte %02h last %0b err %0b, got %02h %0b %0b",
                   want.text, want.last, want.err, out_byte, run_last, depth_error);
      end
    end
  endtask

  // Watch both channels
  always @(posedge clk) begin
    if (rst) begin
      text_q.delete();
      nest_depth = 0;
      str_open = 1'b0;
      pending <= 0;
    end else begin
      if (in_valid && in_ready) predict_token(cmd, data_byte, byte_present, last_byte);
      if (out_valid && out_ready) check_beat();
      pending <= text_q.size();
    end
    fail_count <= fails;
  end

endmodule

/* bench/tb.sv */
module tb;

  localparam int unsigned NEST_MAX = jts_pkg::DEFAULT_STACK_DEPTH;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam int IDLE_PCT = 18;

  logic       clk;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [3:0] cmd = 4'd0;
  logic [7:0] data_byte = 8'h00;
  logic       byte_present = 1'b0;
  logic       last_byte = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       run_last;
  logic       depth_error;

  int fail_count;
  int pending;
  int cycles = 0;

  // shaping state for the stimulus
  bit steady = 1'b0;
  bit hold_req = 1'b0;
  bit open_kinds[$];  // 1 = object
  bit in_text = 1'b0;
  bit text_numeric = 1'b0;

  json_token_serializer_unit uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .cmd(cmd),
    .data_byte(data_byte),
    .byte_present(byte_present),
    .last_byte(last_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_byte(out_byte),
    .run_last(run_last),
    .depth_error(depth_error)
  );

  json_token_checker chk (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .cmd(cmd),
    .data_byte(data_byte),
    .byte_present(byte_present),
    .last_byte(last_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_byte(out_byte),
    .run_last(run_last),
    .depth_error(depth_error),
    .fail_count(fail_count),
    .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic bit take_gap();
    return !steady && ($urandom_range(99) < IDLE_PCT);
  endfunction

  // Offer one transaction; returns in the time step of its acceptance
  task automatic send_item(input logic [3:0] c, input logic [7:0] d,
                           input logic p, input logic l);
    if (take_gap()) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while (take_gap()) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    data_byte <= d;
    byte_present <= p;
    last_byte <= l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Keep a rough picture of the document open so random tokens stay mostly sane
  task automatic issue(input logic [3:0] c, input logic [7:0] d,
                       input logic p, input logic l);
    if (c == jts_bench_pkg::TOK_STRING || c == jts_bench_pkg::TOK_NUMBER) begin
      in_text = !l;
      text_numeric = (c == jts_bench_pkg::TOK_NUMBER);
    end else if (c <= jts_bench_pkg::TOK_NULL) begin
      in_text = 1'b0;
      if ((c == jts_bench_pkg::TOK_ARR_OPEN || c == jts_bench_pkg::TOK_OBJ_OPEN) &&
          open_kinds.size() < NEST_MAX)
        open_kinds.push_back(c == jts_bench_pkg::TOK_OBJ_OPEN);
      else if ((c == jts_bench_pkg::TOK_ARR_CLOSE || c == jts_bench_pkg::TOK_OBJ_CLOSE) &&
               open_kinds.size() > 0)
        void'(open_kinds.pop_back());
    end
    send_item(c, d, p, l);
  endtask

  // Content byte: numbers lean on digits, strings on bytes that need escaping
  function automatic logic [7:0] pick_content(input bit numeric);
    string digits;
    int    roll;
    digits = "0123456789-+.eE";
    roll = $urandom_range(99);
    if (numeric && roll < 70) return digits[$urandom_range(digits.len() - 1)];
    if (roll < 25) return 8'($urandom_range(31));
    if (roll < 35) return $urandom_range(1) ? 8'h22 : 8'h5c;
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [3:0] pick_closer();
    if (open_kinds.size() == 0 || $urandom_range(9) == 0)
      return $urandom_range(1) ? jts_bench_pkg::TOK_OBJ_CLOSE : jts_bench_pkg::TOK_ARR_CLOSE;
    return open_kinds[$] ? jts_bench_pkg::TOK_OBJ_CLOSE : jts_bench_pkg::TOK_ARR_CLOSE;
  endfunction

  task automatic random_token();
    int         roll;
    logic [3:0] c;
    logic [7:0] d;
    logic       p;
    logic       l;
    roll = $urandom_range(99);
    d = 8'($urandom_range(255));
    p = 1'($urandom_range(1));
    l = 1'($urandom_range(1));
    if (in_text && roll < 65) begin
      c = text_numeric ? jts_bench_pkg::TOK_NUMBER : jts_bench_pkg::TOK_STRING;
      d = pick_content(text_numeric);
      p = ($urandom_range(9) != 0);
      l = ($urandom_range(3) == 0);
    end else if (roll >= 65 && roll < 68) begin
      c = 4'($urandom_range(jts_bench_pkg::TOK_UNUSED_HI, jts_bench_pkg::TOK_UNUSED_LO));
    end else begin
      roll = $urandom_range(99);
      if (roll < 22 && open_kinds.size() < 6) begin
        c = $urandom_range(1) ? jts_bench_pkg::TOK_OBJ_OPEN : jts_bench_pkg::TOK_ARR_OPEN;
      end else if (roll < 42) begin
        c = pick_closer();
      end else if (roll < 62) begin
        case ($urandom_range(2))
          0: c = jts_bench_pkg::TOK_TRUE;
          1: c = jts_bench_pkg::TOK_FALSE;
          default: c = jts_bench_pkg::TOK_NULL;
        endcase
      end else begin
        c = (roll < 85) ? jts_bench_pkg::TOK_STRING : jts_bench_pkg::TOK_NUMBER;
        d = pick_content(c == jts_bench_pkg::TOK_NUMBER);
        p = ($urandom_range(9) != 0);
        l = ($urandom_range(4) == 0);
      end
    end
    issue(c, d, p, l);
  endtask

  // Stop offering and wait until every owed byte has come out
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Receiver: random stalls, or one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_ready <= !take_gap();
      end
    end
  end

  // Run limit
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("json_token_serializer_unit verification failed");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // array of literals, then a string with every escape class
    issue(jts_bench_pkg::TOK_ARR_OPEN, 8'hff, 1'b1, 1'b1);
    issue(jts_bench_pkg::TOK_NULL, 8'h00, 1'b0, 1'b0);
    issue(jts_bench_pkg::TOK_TRUE, 8'h00, 1'b0, 1'b0);
    issue(jts_bench_pkg::TOK_FALSE, 8'h00, 1'b0, 1'b0);
    issue(jts_bench_pkg::TOK_STRING, 8'h00, 1'b1, 1'b0);
    issue(jts_bench_pkg::TOK_STRING, 8'h08, 1'b1, 1'b0);
    issue(jts_bench_pkg::TOK_STRING, 8'h09, 1'b1, 1'b0);
    issue(jts_bench_pkg::TOK_STRING, 8'h0a, 1'b1, 1'b0);
    issue(jts_bench_pkg::TOK_STRING, 8'h0c, 1'b1, 1'b0);
    issue(jts_bench_pkg::TOK_STRING, 8'h0d, 1'b1, 1'b0);
    issue(jts_bench_pkg::TOK_STRING, 8'h22, 1'b1, 1'b0);
    issue(jts_bench_pkg::TOK_STRING, 8'h5c, 1'b1, 1'b0);
    issue(jts_bench_pkg::TOK_STRING, 8'hff, 1'b1, 1'b0);
    issue(jts_bench_pkg::TOK_STRING, 8'h0b, 1'b1, 1'b1);
    // one-item number
    issue(jts_bench_pkg::TOK_NUMBER, 8'h37, 1'b1, 1'b1);
    // object: key closed implicitly by a literal, empty key, value with ignored codes
    issue(jts_bench_pkg::TOK_OBJ_OPEN, 8'h00, 1'b0, 1'b0);
    issue(jts_bench_pkg::TOK_STRING, 8'h6b, 1'b1, 1'b0);
    issue(jts_bench_pkg::TOK_TRUE, 8'h00, 1'b0, 1'b0);
    issue(jts_bench_pkg::TOK_NUMBER, 8'h00, 1'b0, 1'b1);
    issue(jts_bench_pkg::TOK_STRING, 8'h76, 1'b1, 1'b0);
    issue(jts_bench_pkg::TOK_UNUSED_LO, 8'h00, 1'b0, 1'b0);
    issue(jts_bench_pkg::TOK_UNUSED_HI, 8'hff, 1'b1, 1'b1);
    issue(jts_bench_pkg::TOK_STRING, 8'h00, 1'b0, 1'b1);
    // mismatched closers, then a closer with nothing open
    issue(jts_bench_pkg::TOK_ARR_CLOSE, 8'h00, 1'b0, 1'b0);
    issue(jts_bench_pkg::TOK_OBJ_CLOSE, 8'h00, 1'b0, 1'b0);
    issue(jts_bench_pkg::TOK_OBJ_CLOSE, 8'h00, 1'b0, 1'b0);

    repeat (100) random_token();

    // sender pauses until the block is empty
    drain_results();

    // receiver holds off while the sender keeps offering
    hold_req = 1'b1;
    repeat (40) random_token();

    // no idling on either side
    steady = 1'b1;
    repeat (80) random_token();
    steady = 1'b0;

    // nest past the stack limit, then unwind past the bottom
    repeat (NEST_MAX + 4) begin
      issue($urandom_range(1) ? jts_bench_pkg::TOK_OBJ_OPEN : jts_bench_pkg::TOK_ARR_OPEN,
            8'($urandom_range(255)), 1'($urandom_range(1)), 1'($urandom_range(1)));
      if ($urandom_range(3) == 0) issue(jts_bench_pkg::TOK_NULL, 8'h00, 1'b0, 1'b0);
    end
    repeat (NEST_MAX + 6) issue(pick_closer(), 8'($urandom_range(255)),
                                1'($urandom_range(1)), 1'($urandom_range(1)));

    repeat (60) random_token();

    drain_results();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("json_token_serializer_unit verification clean");
    else
      $display("json_token_serializer_unit verification failed");
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/jts_pkg.sv
hw/rtl/jts_front.sv
hw/rtl/jts_queue.sv
hw/rtl/jts_back.sv
hw/rtl/json_token_serializer_unit.sv
bench/jts_bench_pkg.sv
bench/json_token_checker.sv
bench/tb.sv
